// File: sv/hbp_pkg.sv
// ----------------------------------------------------------------------------
// hbp_pkg - shared types and constants for the HTTP header block parser
// Byte classes, tag codes, parser phases and default limits.
// ----------------------------------------------------------------------------
package hbp_pkg;

    // Default limits
    localparam int unsigned MAX_FIELD_LEN_DEF = 256;
    localparam int unsigned MAX_BLOCK_LEN_DEF = 65535;

    // Offset counter: saturates one past the 16-bit range
    localparam int          OFF_W   = 17;
    localparam int          BLEN_W  = 16;

    // Delimiter characters
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;

    // Tag attached to every byte
    typedef enum logic [2:0] {
        K_NAME  = 3'd0,
        K_VALUE = 3'd1,
        K_DELIM = 3'd2,
        K_LINE  = 3'd3,
        K_END   = 3'd4,
        K_ERR   = 3'd5,
        K_IGN   = 3'd6
    } kind_t;

    // Parser phase, one-hot
    typedef enum logic [6:0] {
        PH_LINE     = 7'b0000001,
        PH_NAME     = 7'b0000010,
        PH_COLON    = 7'b0000100,
        PH_VALUE    = 7'b0001000,
        PH_LF       = 7'b0010000,
        PH_FINAL_LF = 7'b0100000,
        PH_DONE     = 7'b1000000
    } phase_t;

    // Byte classification flags
    typedef struct packed {
        logic is_token;
        logic is_colon;
        logic is_cr;
        logic is_lf;
        logic is_sp;
    } byte_class_t;

    // Control from the pipeline to the parser core
    typedef struct packed {
        logic step;
        logic start;
    } step_ctrl_t;

    // Per-byte result from the parser core
    typedef struct packed {
        kind_t              kind;
        logic [BLEN_W-1:0]  blen;
    } step_res_t;

    // Token byte: visible ASCII minus the separators
    function automatic logic is_token_f(input logic [7:0] c);
        logic r;
        begin
            r = (c >= 8'd33) && (c <= 8'd126);
            case (c)
                8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A,
                8'h5C, 8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B,
                8'h7D:   r = 1'b0;
                default: r = r;
            endcase
            return r;
        end
    endfunction

endpackage

// File: sv/hbp_in_if.sv
// ----------------------------------------------------------------------------
// hbp_in_if - input byte channel
// Valid/ready channel carrying one header byte and its start flag.
// ----------------------------------------------------------------------------
interface hbp_in_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [7:0] data_byte;

    modport source (output valid, output start_req, output data_byte, input ready);
    modport sink   (input valid, input start_req, input data_byte, output ready);
endinterface

// File: sv/hbp_out_if.sv
// ----------------------------------------------------------------------------
// hbp_out_if - tagged byte channel
// Valid/ready channel carrying the tag, the byte and the block length.
// ----------------------------------------------------------------------------
interface hbp_out_if;
    logic                       valid;
    logic                       ready;
    hbp_pkg::kind_t             kind;
    logic [7:0]                 out_byte;
    logic [hbp_pkg::BLEN_W-1:0] block_length;

    modport source (output valid, output kind, output out_byte, output block_length,
                    input ready);
    modport sink   (input valid, input kind, input out_byte, input block_length,
                    output ready);
endinterface

// File: sv/hbp_byte_class.sv
// ----------------------------------------------------------------------------
// hbp_byte_class - byte classifier
// Decodes one byte into token and delimiter flags.
// ----------------------------------------------------------------------------
module hbp_byte_class (
    input  logic [7:0]           data_byte,
    output hbp_pkg::byte_class_t cls
);

    // Flat decode of the byte
    always_comb
    begin
        cls.is_token = hbp_pkg::is_token_f(data_byte);
        cls.is_colon = (data_byte == hbp_pkg::CH_COLON);
        cls.is_cr    = (data_byte == hbp_pkg::CH_CR);
        cls.is_lf    = (data_byte == hbp_pkg::CH_LF);
        cls.is_sp    = (data_byte == hbp_pkg::CH_SP);
    end

endmodule

// File: sv/hbp_core.sv
// ----------------------------------------------------------------------------
// hbp_core - header parser state and step logic
// Holds phase, field length and block offset; tags one byte per step.
// ----------------------------------------------------------------------------
module hbp_core #(
    parameter int unsigned MAX_FIELD_LEN = hbp_pkg::MAX_FIELD_LEN_DEF,
    parameter int unsigned MAX_BLOCK_LEN = hbp_pkg::MAX_BLOCK_LEN_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hbp_pkg::step_ctrl_t  ctrl,
    input  hbp_pkg::byte_class_t cls,
    output hbp_pkg::step_res_t   res
);

    localparam int OFF_W = hbp_pkg::OFF_W;
    localparam int FL_W  = $clog2(MAX_FIELD_LEN);
    localparam logic [FL_W-1:0]  FL_MAX  = FL_W'(MAX_FIELD_LEN - 1);
    localparam logic [FL_W-1:0]  FL_ONE  = FL_W'(1);
    localparam logic [OFF_W-1:0] OFF_SAT = OFF_W'(1) << hbp_pkg::BLEN_W;
    localparam logic [OFF_W-1:0] LIMIT   = (MAX_BLOCK_LEN > 32'd65535)
                                          ? (OFF_SAT - OFF_W'(1))
                                          : OFF_W'(MAX_BLOCK_LEN);

    hbp_pkg::phase_t  phase_reg, phase_next;
    logic [FL_W-1:0]  field_len_reg, field_len_next;
    logic [OFF_W-1:0] offset_reg, offset_next;

    hbp_pkg::phase_t  ph;
    logic [FL_W-1:0]  fl;
    logic [OFF_W-1:0] off;
    logic             grow_ok;
    hbp_pkg::kind_t   kind;

    // Start flag clears state before the byte is judged
    always_comb
    begin
        ph  = ctrl.start ? hbp_pkg::PH_LINE : phase_reg;
        fl  = ctrl.start ? '0 : field_len_reg;
        off = ctrl.start ? '0 : offset_reg;
    end

    // Phase transition and tag
    always_comb
    begin
        kind           = hbp_pkg::K_IGN;
        phase_next     = ph;
        field_len_next = fl;
        grow_ok        = 1'b0;
        offset_next    = (off < OFF_SAT) ? (off + OFF_W'(1)) : off;
        res.blen       = '0;

        if ((ph != hbp_pkg::PH_DONE) && (off > LIMIT))
        begin
            kind = hbp_pkg::K_ERR;
        end
        else
        begin
            case (ph)
                hbp_pkg::PH_LINE:
                begin
                    if (cls.is_token)
                    begin
                        field_len_next = FL_ONE;
                        kind           = hbp_pkg::K_NAME;
                        phase_next     = hbp_pkg::PH_NAME;
                    end
                    else if (cls.is_cr)
                    begin
                        kind       = hbp_pkg::K_LINE;
                        phase_next = hbp_pkg::PH_FINAL_LF;
                    end
                    else
                        kind = hbp_pkg::K_ERR;
                end
                hbp_pkg::PH_NAME:
                begin
                    grow_ok = (fl < FL_MAX);
                    if (cls.is_token)
                    begin
                        kind = grow_ok ? hbp_pkg::K_NAME : hbp_pkg::K_ERR;
                        if (grow_ok)
                            field_len_next = fl + FL_ONE;
                    end
                    else if (cls.is_colon)
                    begin
                        kind       = hbp_pkg::K_DELIM;
                        phase_next = hbp_pkg::PH_COLON;
                    end
                    else
                        kind = hbp_pkg::K_ERR;
                end
                hbp_pkg::PH_COLON:
                begin
                    // value length restarts from zero here
                    field_len_next = '0;
                    if (cls.is_sp)
                    begin
                        kind       = hbp_pkg::K_DELIM;
                        phase_next = hbp_pkg::PH_VALUE;
                    end
                    else if (cls.is_cr)
                    begin
                        kind       = hbp_pkg::K_LINE;
                        phase_next = hbp_pkg::PH_LF;
                    end
                    else
                    begin
                        grow_ok        = (FL_MAX != '0);
                        kind           = grow_ok ? hbp_pkg::K_VALUE : hbp_pkg::K_ERR;
                        field_len_next = grow_ok ? FL_ONE : '0;
                        phase_next     = hbp_pkg::PH_VALUE;
                    end
                end
                hbp_pkg::PH_VALUE:
                begin
                    grow_ok = (fl < FL_MAX);
                    if (cls.is_cr)
                    begin
                        kind       = hbp_pkg::K_LINE;
                        phase_next = hbp_pkg::PH_LF;
                    end
                    else
                    begin
                        kind = grow_ok ? hbp_pkg::K_VALUE : hbp_pkg::K_ERR;
                        if (grow_ok)
                            field_len_next = fl + FL_ONE;
                    end
                end
                hbp_pkg::PH_LF:
                begin
                    if (cls.is_lf)
                    begin
                        kind       = hbp_pkg::K_LINE;
                        phase_next = hbp_pkg::PH_LINE;
                    end
                    else
                        kind = hbp_pkg::K_ERR;
                end
                hbp_pkg::PH_FINAL_LF:
                begin
                    if (cls.is_lf)
                    begin
                        kind       = hbp_pkg::K_END;
                        res.blen   = off[hbp_pkg::BLEN_W-1:0];
                        phase_next = hbp_pkg::PH_DONE;
                    end
                    else
                        kind = hbp_pkg::K_ERR;
                end
                default:
                    kind = hbp_pkg::K_IGN;
            endcase
        end

        // any error parks the parser until the next start
        if (kind == hbp_pkg::K_ERR)
            phase_next = hbp_pkg::PH_DONE;

        res.kind = kind;
    end

    // State registers, updated once per processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= hbp_pkg::PH_LINE;
            field_len_reg <= '0;
            offset_reg    <= '0;
        end
        else if (ctrl.step)
        begin
            phase_reg     <= phase_next;
            field_len_reg <= field_len_next;
            offset_reg    <= offset_next;
        end
    end

    // Checks
    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("parser phase not one-hot");

    a_end_parks: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.step && (res.kind == hbp_pkg::K_END)) |=> (phase_reg == hbp_pkg::PH_DONE))
        else $error("block end did not park the parser");

    a_field_bound: assert property (@(posedge clk) disable iff (!rst_n)
        field_len_reg <= FL_MAX)
        else $error("field length beyond limit");

endmodule

// File: sv/http_header_block_parser_unit.sv
// ----------------------------------------------------------------------------
// http_header_block_parser_unit - HTTP/1.1 header block byte tagger
// Tags each byte of a header block and reports the block length at its end.
// ----------------------------------------------------------------------------
//  channel | dir | payload                              | handshake
//  in_ch   | in  | start_req, data_byte                 | valid/ready
//  out_ch  | out | kind, out_byte, block_length         | valid/ready
//
//  One byte per cycle while the output is not stalled; each byte passes the
//  input register, the step logic and the result register in that order.
//  The phase and offset registers close a loop through the step logic.
//  Reset puts the parser at line start with offset zero; no clearing pass.
//  A stalled output holds the result; the input register keeps accepting as
//  long as the result register frees up in the same cycle.
// ----------------------------------------------------------------------------
module http_header_block_parser_unit #(
    parameter int unsigned MAX_FIELD_LEN = hbp_pkg::MAX_FIELD_LEN_DEF,
    parameter int unsigned MAX_BLOCK_LEN = hbp_pkg::MAX_BLOCK_LEN_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    hbp_in_if.sink    in_ch,
    hbp_out_if.source out_ch
);

    logic                       stage_valid_reg;
    logic                       stage_start_reg;
    logic [7:0]                 stage_byte_reg;
    logic                       out_valid_reg;
    hbp_pkg::kind_t             out_kind_reg;
    logic [7:0]                 out_byte_reg;
    logic [hbp_pkg::BLEN_W-1:0] out_blen_reg;

    logic                 advance;
    logic                 in_xfer;
    hbp_pkg::step_ctrl_t  ctrl;
    hbp_pkg::byte_class_t cls;
    hbp_pkg::step_res_t   res;

    // Handshake
    assign advance     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !stage_valid_reg || advance;
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign ctrl.step   = stage_valid_reg && advance;
    assign ctrl.start  = stage_start_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (in_xfer)
            stage_valid_reg <= 1'b1;
        else if (ctrl.step)
            stage_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            stage_start_reg <= in_ch.start_req;
            stage_byte_reg  <= in_ch.data_byte;
        end
    end

    hbp_byte_class u_class (
        .data_byte (stage_byte_reg),
        .cls       (cls)
    );

    hbp_core #(
        .MAX_FIELD_LEN (MAX_FIELD_LEN),
        .MAX_BLOCK_LEN (MAX_BLOCK_LEN)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .cls   (cls),
        .res   (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= stage_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            out_kind_reg <= res.kind;
            out_byte_reg <= stage_byte_reg;
            out_blen_reg <= res.blen;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.kind         = out_kind_reg;
    assign out_ch.out_byte     = out_byte_reg;
    assign out_ch.block_length = out_blen_reg;

    // Checks
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ch.ready)
        else $error("input stalled with empty result register");

    a_blen_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg != hbp_pkg::K_END)) |-> (out_blen_reg == '0))
        else $error("block length set on a byte that is not block end");

    a_step_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.step |=> out_valid_reg)
        else $error("processed byte left no result");

endmodule
